@@ sv/mlpq_pkg.sv @@
// Shared types and codes for the multilevel priority queue.
package mlpq_pkg;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    localparam logic [2:0] ST_ENQUEUED = 3'd0;
    localparam logic [2:0] ST_DEQUEUED = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] value;
        logic [7:0]         priority_req;
    } req_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [2:0]         status;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DATA
    } state_t;

    typedef struct packed {
        logic accept;
        logic execute;
        logic deliver;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic deq_hit;
    } ctrl_sts_t;

endpackage

@@ sv/mlpq_ctrl.sv @@
// Sequencer for the multilevel priority queue: accept, execute, deliver read data.
module mlpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  mlpq_pkg::ctrl_sts_t sts,
    output mlpq_pkg::ctrl_cmd_t cmd
);
    import mlpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.execute = 1'b1;
                    state_next  = sts.deq_hit ? S_DATA : S_IDLE;
                end
            end
            S_DATA:
            begin
                cmd.deliver = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/mlpq_dp.sv @@
// Datapath of the multilevel priority queue: level flags, pointer and entry memories.
module mlpq_dp #(
    parameter int LEVELS = 8,
    parameter int DEPTH  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mlpq_pkg::req_t      req,
    output mlpq_pkg::rsp_t      rsp,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  mlpq_pkg::ctrl_cmd_t cmd,
    output mlpq_pkg::ctrl_sts_t sts
);
    import mlpq_pkg::*;

    localparam int LW = $clog2(LEVELS);
    localparam int SW = $clog2(DEPTH);
    localparam int AW = $clog2(LEVELS * DEPTH);

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] slot);
        logic [SW-1:0] res;
        if (slot == SW'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = slot + SW'(1);
        end
        return res;
    endfunction

    // level flags and captured request
    logic [LEVELS-1:0] nonempty_reg;
    logic [LEVELS-1:0] nonempty_next;
    logic              req_deq_reg;
    logic              req_bad_reg;
    logic [31:0]       req_value_reg;
    logic [LW-1:0]     lvl_reg;

    // pointer memory: {head, tail} per level
    logic [2*SW-1:0]   ptr_mem [LEVELS];
    logic [2*SW-1:0]   ptr_rd_reg;
    logic              ptr_we;
    logic [2*SW-1:0]   ptr_wdata;

    // entry memory
    logic [31:0]       entry_mem [LEVELS*DEPTH];
    logic [31:0]       entry_rd_reg;
    logic              entry_we;
    logic              entry_re;
    logic [SW-1:0]     entry_slot;
    logic [AW-1:0]     entry_addr;

    logic              out_valid_reg;
    logic signed [31:0] out_data_reg;
    logic [2:0]        out_status_reg;
    logic              out_load;
    logic signed [31:0] out_data_next;
    logic [2:0]        out_status_next;

    logic [LW-1:0]     pick_lvl;
    logic [LW-1:0]     lvl_sel;
    logic              bad_sel;
    logic [SW-1:0]     head;
    logic [SW-1:0]     tail;
    logic [SW-1:0]     tail_nx;
    logic              lvl_ne;

    // highest non-empty level
    always_comb
    begin
        pick_lvl = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (nonempty_reg[i])
            begin
                pick_lvl = LW'(i);
            end
        end
    end

    always_comb
    begin
        if (req.cmd == CMD_DEQUEUE)
        begin
            lvl_sel = pick_lvl;
            bad_sel = ~|nonempty_reg;
        end
        else
        begin
            lvl_sel = req.priority_req[LW-1:0];
            bad_sel = (int'(req.priority_req) >= LEVELS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_deq_reg   <= (req.cmd == CMD_DEQUEUE);
            req_bad_reg   <= bad_sel;
            req_value_reg <= req.value;
            lvl_reg       <= lvl_sel;
            ptr_rd_reg    <= ptr_mem[lvl_sel];
        end
        if (ptr_we)
        begin
            ptr_mem[lvl_reg] <= ptr_wdata;
        end
    end

    assign head    = ptr_rd_reg[2*SW-1:SW];
    assign tail    = ptr_rd_reg[SW-1:0];
    assign tail_nx = next_slot(tail);
    assign lvl_ne  = nonempty_reg[lvl_reg];

    always_comb
    begin
        nonempty_next   = nonempty_reg;
        ptr_we          = 1'b0;
        ptr_wdata       = ptr_rd_reg;
        entry_we        = 1'b0;
        entry_re        = 1'b0;
        entry_slot      = '0;
        out_load        = 1'b0;
        out_data_next   = '0;
        out_status_next = ST_ENQUEUED;
        if (cmd.execute)
        begin
            if (!req_deq_reg)
            begin
                out_load = 1'b1;
                if (req_bad_reg)
                begin
                    out_status_next = ST_INVALID;
                end
                else if (!lvl_ne)
                begin
                    // restart an empty level at slot zero
                    nonempty_next[lvl_reg] = 1'b1;
                    ptr_we     = 1'b1;
                    ptr_wdata  = '0;
                    entry_we   = 1'b1;
                    entry_slot = '0;
                end
                else if (tail_nx == head)
                begin
                    out_status_next = ST_OVERFLOW;
                end
                else
                begin
                    ptr_we     = 1'b1;
                    ptr_wdata  = {head, tail_nx};
                    entry_we   = 1'b1;
                    entry_slot = tail_nx;
                end
            end
            else if (req_bad_reg)
            begin
                out_load        = 1'b1;
                out_data_next   = '1;
                out_status_next = ST_EMPTY;
            end
            else
            begin
                entry_re   = 1'b1;
                entry_slot = head;
                ptr_we     = 1'b1;
                if (head == tail)
                begin
                    nonempty_next[lvl_reg] = 1'b0;
                    ptr_wdata = '0;
                end
                else
                begin
                    ptr_wdata = {next_slot(head), tail};
                end
            end
        end
        else if (cmd.deliver)
        begin
            out_load        = 1'b1;
            out_data_next   = entry_rd_reg;
            out_status_next = ST_DEQUEUED;
        end
    end

    assign entry_addr = AW'(lvl_reg) * AW'(DEPTH) + AW'(entry_slot);

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[entry_addr] <= req_value_reg;
        end
        if (entry_re)
        begin
            entry_rd_reg <= entry_mem[entry_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nonempty_reg <= nonempty_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign rsp.data     = out_data_reg;
    assign rsp.status   = out_status_reg;
    assign sts.out_free = !out_valid_reg || rsp_ready;
    assign sts.deq_hit  = req_deq_reg && !req_bad_reg;

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute || cmd.deliver) |-> (!out_valid_reg || rsp_ready))
        else $error("result loaded while output register still full");

    a_hit_then_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && sts.deq_hit) |=> cmd.deliver)
        else $error("dequeue read not delivered in the following cycle");

    a_flags_only_on_execute: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.execute |=> $stable(nonempty_reg))
        else $error("level flags changed outside execute");

    a_pick_is_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && sts.deq_hit) |-> lvl_ne)
        else $error("dequeue picked an empty level");

endmodule

@@ sv/multilevel_priority_queue_top.sv @@
// Top level of the multilevel priority queue: controller plus datapath.
//
// Use: one circular FIFO per priority level, higher level number wins.
// Request channel (req_valid/req_ready, payload req): cmd selects enqueue
// of value at level priority_req, or dequeue of the head of the highest
// non-empty level. Response channel (rsp_valid/rsp_ready, payload rsp):
// exactly one transaction per request, carrying data and status
// (enqueued, dequeued, invalid level, overflow, or empty with data -1).
// The response of an enqueue, an invalid level or an empty dequeue is
// loaded into the output register by the execute step; a dequeue that hits
// adds a deliver step, as the read of the entry memory is registered. Each
// request passes accept and execute, and deliver for a dequeue that hits, on
// one sequencer, so no new request is taken before the last one is through.
// The block accepts a new request while the previous response waits in
// the output register; when the receiver stalls, the next request holds in
// its execute step until the output register frees up.
// Reset clears every level flag, so all levels are empty, and drops any
// pending response. No clearing pass is needed: pointer and entry memory
// contents are only used for levels whose flag is set.
module multilevel_priority_queue_top #(
    parameter int LEVELS = 8,
    parameter int DEPTH  = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mlpq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mlpq_pkg::rsp_t rsp
);
    import mlpq_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // sequence each transaction: accept, execute, deliver
    mlpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // level flags, pointers, entries and the output register
    mlpq_dp #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ tb/tb_top.sv @@
// Testbench for the multilevel priority queue: directed and random traffic, checked per level.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mlpq_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int NUM_LEVELS = 8;
    localparam int SLOTS      = 8;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int MAX_GAP    = 6;
    localparam int DRAIN_WAIT = 10;

    // Extreme data words, used both in directed items and mixed into random ones.
    localparam logic signed [31:0] WORD_MAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0] WORD_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_ONES = -32'sd1;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Idle knobs: the sender gaps and the receiver stalls only while these are set,
    // so the run also has stretches at full rate.
    bit   gaps_on   = 1'b1;
    bit   stalls_on = 1'b1;

    int   mismatches = 0;

    // Answers the block owes, oldest first.
    rsp_t owed_answers[$];

    // Shadow of the per-level FIFOs.
    logic [SLOT_W-1:0]  lvl_head  [NUM_LEVELS];
    logic [SLOT_W-1:0]  lvl_tail  [NUM_LEVELS];
    bit                 lvl_filled[NUM_LEVELS];
    logic signed [31:0] lvl_words [NUM_LEVELS][SLOTS];

    multilevel_priority_queue_top #(
        .LEVELS(NUM_LEVELS),
        .DEPTH (SLOTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Queue prediction
    // ------------------------------------------------------------------

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
        return (slot == SLOTS - 1) ? '0 : slot + 1'b1;
    endfunction

    // Apply one accepted request to the shadow FIFOs and return the answer it earns.
    function automatic rsp_t predict_answer(input req_t item);
        rsp_t              ans;
        logic [SLOT_W-1:0] slot;
        int                lv;
        ans.data   = '0;
        ans.status = ST_ENQUEUED;
        if (item.cmd == CMD_ENQUEUE)
        begin
            if (item.priority_req >= NUM_LEVELS)
            begin
                ans.status = ST_INVALID;
            end
            else
            begin
                lv = int'(item.priority_req);
                if (!lvl_filled[lv])
                begin
                    // An empty level restarts at slot 0.
                    lvl_head[lv]     = '0;
                    lvl_tail[lv]     = '0;
                    lvl_filled[lv]   = 1'b1;
                    lvl_words[lv][0] = item.value;
                end
                else if (next_slot(lvl_tail[lv]) == lvl_head[lv])
                begin
                    ans.status = ST_OVERFLOW;
                end
                else
                begin
                    slot                = next_slot(lvl_tail[lv]);
                    lvl_tail[lv]        = slot;
                    lvl_words[lv][slot] = item.value;
                end
            end
        end
        else
        begin
            ans.data   = WORD_ONES;
            ans.status = ST_EMPTY;
            // Scan from the highest level down; the first one holding data wins.
            for (lv = NUM_LEVELS - 1; lv >= 0; lv--)
            begin
                if (lvl_filled[lv])
                begin
                    ans.data   = lvl_words[lv][lvl_head[lv]];
                    ans.status = ST_DEQUEUED;
                    if (lvl_head[lv] == lvl_tail[lv])
                    begin
                        // Last entry gone: the level empties and its pointers rewind.
                        lvl_filled[lv] = 1'b0;
                        lvl_head[lv]   = '0;
                        lvl_tail[lv]   = '0;
                    end
                    else
                    begin
                        lvl_head[lv] = next_slot(lvl_head[lv]);
                    end
                    break;
                end
            end
        end
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    function automatic req_t make_req(input logic cmd, input logic signed [31:0] word,
                                      input logic [7:0] level);
        req_t item;
        item.cmd          = cmd;
        item.value        = word;
        item.priority_req = level;
        return item;
    endfunction

    // Send one request transaction. Each call starts from the falling edge after the
    // previous acceptance, so valid is dropped only when a gap actually follows and
    // is never lowered and raised in the same step.
    task automatic send_request(input req_t item);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            // Scramble the idle payload; the block must ignore it.
            req       <= make_req(1'($urandom), 32'($urandom), 8'($urandom));
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        // Accepted at this edge: book the answer it must produce.
        owed_answers.push_back(predict_answer(item));
    endtask

    // ------------------------------------------------------------------
    // Response side: drive ready with random stalls, check every transaction
    // ------------------------------------------------------------------

    initial
    begin
        int   stall;
        rsp_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = stalls_on ? $urandom_range(0, MAX_GAP) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            if (owed_answers.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected response data=%0d status=%0d",
                         $time, rsp.data, rsp.status);
            end
            else
            begin
                want = owed_answers.pop_front();
                if (rsp.data !== want.data)
                begin
                    mismatches++;
                    $display("%0t: data mismatch: expected %0d, actual %0d",
                             $time, want.data, rsp.data);
                end
                if (rsp.status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, rsp.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Dequeue with every level empty: data all ones, status empty.
    task automatic test_empty_queue();
        send_request(make_req(CMD_DEQUEUE, WORD_MAX, 8'd0));
        send_request(make_req(CMD_DEQUEUE, '0, 8'hff));
    endtask

    // Enqueue to levels past the top: rejected, state untouched.
    task automatic test_invalid_level();
        send_request(make_req(CMD_ENQUEUE, 32'sd11, 8'(NUM_LEVELS)));
        send_request(make_req(CMD_ENQUEUE, WORD_MIN, 8'hff));
        send_request(make_req(CMD_ENQUEUE, 32'sd12, 8'h80));
    endtask

    // Fill one level to capacity with extreme words, then push once more to overflow.
    task automatic test_fill_and_overflow();
        logic signed [31:0] words[SLOTS];
        words = '{WORD_MAX, WORD_MIN, WORD_ONES, 32'sd0,
                  32'sh5555_5555, 32'shaaaa_aaaa, 32'sd1, -32'sd2};
        foreach (words[i])
            send_request(make_req(CMD_ENQUEUE, words[i], 8'd3));
        send_request(make_req(CMD_ENQUEUE, 32'sd99, 8'd3));
    endtask

    // Higher level beats older entries below; draining a level rewinds it.
    task automatic test_level_order();
        send_request(make_req(CMD_ENQUEUE, 32'sd70, 8'd0));
        send_request(make_req(CMD_ENQUEUE, 32'sd77, 8'(NUM_LEVELS - 1)));
        send_request(make_req(CMD_DEQUEUE, '0, '0));
        send_request(make_req(CMD_ENQUEUE, 32'sd78, 8'(NUM_LEVELS - 1)));
        send_request(make_req(CMD_DEQUEUE, '0, '0));
        send_request(make_req(CMD_DEQUEUE, '0, '0));
        send_request(make_req(CMD_ENQUEUE, 32'sd33, 8'd3));
    endtask

    // Random traffic in rounds. Each round picks an enqueue bias and a window of
    // levels: narrow windows with a heavy enqueue bias drive levels into overflow
    // and pointer wrap, drain-heavy rounds empty the whole queue.
    task automatic test_random_traffic(input int rounds, input int per_round);
        int                 enq_pct;
        int                 lvl_lo;
        int                 lvl_hi;
        logic [7:0]         level;
        logic signed [31:0] word;
        for (int r = 0; r < rounds; r++)
        begin
            case (r % 3)
                0:       enq_pct = 80;
                1:       enq_pct = 25;
                default: enq_pct = 50;
            endcase
            lvl_lo = $urandom_range(0, NUM_LEVELS - 1);
            lvl_hi = ($urandom_range(0, 1) == 0) ? lvl_lo : NUM_LEVELS - 1;
            if (lvl_hi - lvl_lo < 1 && $urandom_range(0, 2) == 0)
                lvl_lo = 0;
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < per_round; n++)
            begin
                case ($urandom_range(0, 7))
                    0:       word = WORD_MAX;
                    1:       word = WORD_MIN;
                    2:       word = ($urandom_range(0, 1) == 0) ? WORD_ONES : '0;
                    default: word = $urandom;
                endcase
                // A small share of enqueues aim above the top level.
                if ($urandom_range(0, 99) < 8)
                    level = 8'($urandom_range(NUM_LEVELS, 255));
                else
                    level = 8'($urandom_range(lvl_lo, lvl_hi));
                if ($urandom_range(0, 99) < enq_pct)
                    send_request(make_req(CMD_ENQUEUE, word, level));
                else
                    send_request(make_req(CMD_DEQUEUE, word, 8'($urandom)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        foreach (lvl_filled[i])
        begin
            lvl_filled[i] = 1'b0;
            lvl_head[i]   = '0;
            lvl_tail[i]   = '0;
        end
        // Hold reset, then release it away from the rising edge.
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_invalid_level();
        test_fill_and_overflow();
        test_level_order();
        test_random_traffic(9, 50);

        // Stop requesting, then wait for every owed answer plus a spare DRAIN_WAIT stretch
        // so that a stray extra response is still caught.
        @(negedge clk);
        req_valid <= 1'b0;
        wait (owed_answers.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
sv/mlpq_pkg.sv
sv/mlpq_ctrl.sv
sv/mlpq_dp.sv
sv/multilevel_priority_queue_top.sv
tb/tb_top.sv
